/* hw/rtl/tcw_pkg.sv */
// Shared types, constants and helpers of the text console writer.
// No dependencies; every other RTL file but tcw_ram imports this package.
`default_nettype none

package tcw_pkg;

  localparam int COLS   = 80;
  localparam int ROWS   = 25;
  localparam int CELLS  = COLS * ROWS;
  localparam int COL_W  = $clog2(COLS);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int ADDR_W = $clog2(CELLS);
  localparam int CNT_W  = $clog2(CELLS + 1);
  localparam int CELL_W = 16;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] NEWLINE      = 8'd10;
  localparam logic [7:0] SPACE        = 8'd32;
  localparam logic [7:0] ATTR_RESET   = 8'd15;

  // command codes of the input beat
  localparam logic [2:0] CMD_PUT_CURSOR = 3'd0;
  localparam logic [2:0] CMD_PUT_POS    = 3'd1;
  localparam logic [2:0] CMD_ERASE      = 3'd2;
  localparam logic [2:0] CMD_CLEAR      = 3'd3;
  localparam logic [2:0] CMD_READ       = 3'd4;

  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] char_code;
    logic [7:0] attr;
    logic [6:0] col;
    logic [4:0] row;
  } item_t;

  typedef struct packed {
    logic [10:0] cursor_cell;
    logic [7:0]  read_char;
    logic [7:0]  read_attr;
    logic        scrolled;
  } result_t;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_PUT,
    OP_ERASE,
    OP_CLEAR,
    OP_READ
  } op_kind_t;

  // classified command as it travels through the queue
  typedef struct packed {
    op_kind_t         kind;
    logic             use_cursor;
    logic             newline;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [7:0]       chr;
    logic [7:0]       atr;
  } op_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [2:0] {
    BK_INIT,
    BK_IDLE,
    BK_READ,
    BK_SCROLL,
    BK_CLEAR
  } back_state_t;

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                   input logic [COL_W-1:0] c);
    return ADDR_W'(r) * ADDR_W'(COLS) + ADDR_W'(c);
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/text_console_writer_top.sv */
// Top level of the text console writer: front end, command queue, back end.
// Depends on tcw_pkg, tcw_front, tcw_queue, tcw_back (and tcw_ram below it).
`default_nettype none

// Text console writer, 80x25 character cells of {attribute, character}.
// After reset the store is cleared to zero by a pass of one cell per cycle;
// busy stays high during that pass. A command beat is taken when start is
// high and busy is low; busy otherwise rises only while the two-entry command
// queue is full. Every command yields exactly one result beat, shown on result
// for one cycle with done high; the receiver must take it then, it cannot
// stall the block. At the earliest, a command reaches its result through the
// queue slot and then the done/result registers. Work per command in the back
// end, set by the single write port of the cell store:
//   put, erase, unused code: done in the idle state (so a character stream
//     runs at one beat per cycle while no put scrolls)
//   read: an extra read state (registered store read)
//   put that scrolls: a row-offset copy through the store,
//     one cell per cycle, then the bottom row zeroed
//   clear: a sweep through the store, one cell per cycle
// default_attr (cfg_we/cfg_data) is sampled when a command enters, so write
// it only while no command is in flight.
module text_console_writer_top
  import tcw_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  output logic            busy,
  input  wire item_t      item,
  input  wire logic       cfg_we,
  input  wire logic [7:0] cfg_data,
  output logic            done,
  output result_t         result
);

  q_status_t q_status;
  logic      push;
  logic      pop;
  logic      init_active;
  op_t       push_op;
  op_t       head;

  tcw_front u_front (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .item     (item),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .q_status (q_status),
    .back_init(init_active),
    .busy     (busy),
    .push     (push),
    .op       (push_op)
  );

  tcw_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .push_op(push_op),
    .pop    (pop),
    .head   (head),
    .status (q_status)
  );

  tcw_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .q_status   (q_status),
    .pop        (pop),
    .init_active(init_active),
    .done       (done),
    .result     (result)
  );

endmodule

`default_nettype wire

/* hw/rtl/tcw_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* hw/rtl/tcw_front.sv */
// Front end: accepts command beats, holds the default attribute register,
// saturates positions and classifies each command. Depends on tcw_pkg.
`default_nettype none

module tcw_front
  import tcw_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      start,
  input  wire item_t     item,
  input  wire logic      cfg_we,
  input  wire logic [7:0] cfg_data,
  input  wire q_status_t q_status,
  input  wire logic      back_init,
  output logic           busy,
  output logic           push,
  output op_t            op
);

  logic [7:0]       default_attr;
  logic [COL_W-1:0] col_sat;
  logic [ROW_W-1:0] row_sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      default_attr <= ATTR_RESET;
    end else if (cfg_we) begin
      default_attr <= cfg_data;
    end
  end

  assign busy = q_status.full | back_init;
  assign push = start & ~busy;

  always_comb begin
    col_sat = (item.col >= COLS) ? COL_W'(COLS - 1) : COL_W'(item.col);
    row_sat = (item.row >= ROWS) ? ROW_W'(ROWS - 1) : ROW_W'(item.row);

    op.use_cursor = 1'b0;
    op.newline    = (item.char_code == NEWLINE);
    op.row        = row_sat;
    op.col        = col_sat;
    op.chr        = item.char_code;
    op.atr        = (item.attr == 8'd0) ? default_attr : item.attr;
    op.kind       = OP_NOP;
    unique case (item.cmd)
      CMD_PUT_CURSOR: begin
        op.kind       = OP_PUT;
        op.use_cursor = 1'b1;
      end
      CMD_PUT_POS: op.kind = OP_PUT;
      CMD_ERASE: begin
        op.kind = OP_ERASE;
        op.atr  = default_attr;
      end
      CMD_CLEAR: begin
        op.kind = OP_CLEAR;
        op.atr  = default_attr;
      end
      CMD_READ: op.kind = OP_READ;
      default:  op.kind = OP_NOP;
    endcase
  end

endmodule

`default_nettype wire

/* hw/rtl/tcw_queue.sv */
// Short command queue between front and back end.
// Depends on tcw_pkg for op_t and the queue depth.
`default_nettype none

module tcw_queue
  import tcw_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire op_t  push_op,
  input  wire logic pop,
  output op_t       head,
  output q_status_t status
);

  op_t               slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic [QCNT_W-1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr + QPTR_W'(1);
      end
      if (pop) begin
        rptr <= (rptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_op;
    end
  end

  assign head         = slots[rptr];
  assign status.full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign status.empty = (count == '0);

endmodule

`default_nettype wire

/* hw/rtl/tcw_back.sv */
// Back end: executes queued commands against the cell store, runs the
// reset clear, the clear sweep and the scroll copy. Depends on tcw_pkg, tcw_ram.
`default_nettype none

module tcw_back
  import tcw_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire op_t       head,
  input  wire q_status_t q_status,
  output logic           pop,
  output logic           init_active,
  output logic           done,
  output result_t        result
);

  back_state_t state, state_next;

  logic [CNT_W-1:0]  cnt, cnt_next;
  logic [ROW_W-1:0]  cur_row, cur_row_next;
  logic [COL_W-1:0]  cur_col, cur_col_next;
  logic [7:0]        blank_attr, blank_attr_next;
  logic              done_next;
  result_t           result_next;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [CELL_W-1:0] ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [CELL_W-1:0] ram_rdata;

  logic [ROW_W-1:0]  tgt_row;
  logic [COL_W-1:0]  tgt_col;
  logic [COL_W-1:0]  adv_col;
  logic              wrap;
  logic              last;
  logic              at_home;
  logic              have_op;

  tcw_ram #(
    .WIDTH(CELL_W),
    .DEPTH(CELLS)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // put target and cursor advance
  always_comb begin
    have_op = (state == BK_IDLE) && !q_status.empty;
    tgt_row = head.use_cursor ? cur_row : head.row;
    tgt_col = head.use_cursor ? cur_col : head.col;
    adv_col = head.newline ? COL_W'(COLS - 1) : tgt_col;
    wrap    = (adv_col == COL_W'(COLS - 1));
    last    = wrap && (tgt_row == ROW_W'(ROWS - 1));
    at_home = (cur_row == '0) && (cur_col == '0);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      BK_INIT:   if (cnt == CNT_W'(CELLS - 1)) state_next = BK_IDLE;
      BK_IDLE: begin
        if (have_op) begin
          unique case (head.kind)
            OP_PUT:   state_next = last ? BK_SCROLL : BK_IDLE;
            OP_CLEAR: state_next = BK_CLEAR;
            OP_READ:  state_next = BK_READ;
            default:  state_next = BK_IDLE;
          endcase
        end
      end
      BK_READ:   state_next = BK_IDLE;
      BK_SCROLL: if (cnt == CNT_W'(CELLS)) state_next = BK_IDLE;
      BK_CLEAR:  if (cnt == CNT_W'(CELLS - 1)) state_next = BK_IDLE;
      default:   state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    pop             = 1'b0;
    ram_we          = 1'b0;
    ram_waddr       = ADDR_W'(cnt);
    ram_wdata       = '0;
    ram_raddr       = cell_addr(head.row, head.col);
    cnt_next        = '0;
    cur_row_next    = cur_row;
    cur_col_next    = cur_col;
    blank_attr_next = blank_attr;
    done_next       = 1'b0;
    result_next     = '0;

    unique case (state)
      BK_INIT: begin
        ram_we   = 1'b1;
        cnt_next = cnt + CNT_W'(1);
      end
      BK_IDLE: begin
        if (have_op) begin
          pop = 1'b1;
          unique case (head.kind)
            OP_PUT: begin
              ram_we    = !head.newline;
              ram_waddr = cell_addr(tgt_row, tgt_col);
              ram_wdata = {head.atr, head.chr};
              if (last) begin
                cur_row_next = ROW_W'(ROWS - 1);
                cur_col_next = '0;
              end else if (wrap) begin
                cur_row_next = tgt_row + ROW_W'(1);
                cur_col_next = '0;
                done_next    = 1'b1;
              end else begin
                cur_row_next = tgt_row;
                cur_col_next = adv_col + COL_W'(1);
                done_next    = 1'b1;
              end
            end
            OP_ERASE: begin
              done_next = 1'b1;
              if (!at_home) begin
                if (cur_col == '0) begin
                  cur_row_next = cur_row - ROW_W'(1);
                  cur_col_next = COL_W'(COLS - 1);
                end else begin
                  cur_col_next = cur_col - COL_W'(1);
                end
                ram_we    = 1'b1;
                ram_waddr = cell_addr(cur_row_next, cur_col_next);
                ram_wdata = {head.atr, SPACE};
              end
            end
            OP_CLEAR: begin
              blank_attr_next = head.atr;
              cur_row_next    = '0;
              cur_col_next    = '0;
            end
            OP_READ: begin
            end
            default: done_next = 1'b1;
          endcase
        end
      end
      BK_READ: begin
        done_next             = 1'b1;
        result_next.read_char = ram_rdata[7:0];
        result_next.read_attr = ram_rdata[15:8];
      end
      BK_SCROLL: begin
        // read runs one row ahead of the write, bottom row gets zero
        ram_raddr = ADDR_W'(cnt + CNT_W'(COLS));
        ram_we    = (cnt != '0);
        ram_waddr = ADDR_W'(cnt - CNT_W'(1));
        ram_wdata = ((cnt - CNT_W'(1)) < CNT_W'(CELLS - COLS)) ? ram_rdata : '0;
        cnt_next  = cnt + CNT_W'(1);
        if (cnt == CNT_W'(CELLS)) begin
          cnt_next             = '0;
          done_next            = 1'b1;
          result_next.scrolled = 1'b1;
        end
      end
      BK_CLEAR: begin
        ram_we    = 1'b1;
        ram_wdata = (cnt < CNT_W'(CELLS - COLS)) ? {blank_attr, SPACE} : '0;
        cnt_next  = cnt + CNT_W'(1);
        if (cnt == CNT_W'(CELLS - 1)) begin
          cnt_next             = '0;
          done_next            = 1'b1;
          result_next.scrolled = 1'b1;
        end
      end
      default: begin
      end
    endcase

    result_next.cursor_cell = 11'(cell_addr(cur_row_next, cur_col_next));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= BK_INIT;
      cnt     <= '0;
      cur_row <= '0;
      cur_col <= '0;
      done    <= 1'b0;
    end else begin
      state   <= state_next;
      cnt     <= (state_next == BK_IDLE) ? '0 : cnt_next;
      cur_row <= cur_row_next;
      cur_col <= cur_col_next;
      done    <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    blank_attr <= blank_attr_next;
    result     <= result_next;
  end

  assign init_active = (state == BK_INIT);

  assert property (@(posedge clk) disable iff (rst)
    (cur_row < ROW_W'(ROWS)) && (cur_col < COL_W'(COLS)))
    else $error("cursor outside the screen");

  assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_status.empty)
    else $error("pop from empty queue");

  assert property (@(posedge clk) disable iff (rst)
    (state == BK_SCROLL) |-> (cnt <= CNT_W'(CELLS)))
    else $error("scroll sweep overran");

  assert property (@(posedge clk) disable iff (rst)
    (state == BK_INIT) |=> !done)
    else $error("result during reset clear");

endmodule

`default_nettype wire

/* tb/text_console_writer_top_tb.sv */
// Self-checking bench for text_console_writer_top: directed and random console commands
// checked against an in-bench model of the screen, cursor and default attribute.
// Depends on tcw_pkg and the text_console_writer_top RTL.
module text_console_writer_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tcw_pkg::*;

  // Hang guard. The slowest legal run is the clear pass after reset plus about
  // 1700 beats that each scroll behind a sender gap. Allow three times that.
  localparam int LIMIT       = 10_500_000;
  localparam int TAIL_CYCLES = 2100;       // a scroll's worth, to catch stray beats
  localparam int PHASE_ITEMS = 410;        // four random phases
  localparam int N_PHASES    = 4;
  localparam logic [2:0] CMD_UNUSED_LO = 3'd5;  // codes 5..7 do nothing
  localparam logic [2:0] CMD_UNUSED_HI = 3'd7;
  localparam logic [7:0] PRINTABLE_LAST = 8'd126;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  logic       busy;
  item_t      cmd_beat = '0;
  logic       cfg_we = 1'b0;
  logic [7:0] cfg_data = 8'h00;
  logic       done;
  result_t    res_beat;

  text_console_writer_top dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .item     (cmd_beat),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .done     (done),
    .result   (res_beat)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Console model: cell contents {attr, char}, cursor and blank attribute
  // ---------------------------------------------------------------------------
  logic [15:0] screen [0:CELLS-1];
  logic [10:0] cursor;
  logic [7:0]  blank_attr;

  item_t   cmd_backlog [$];     // commands not yet handed to the block
  result_t awaited [$];         // expected result beats, oldest first
  logic    beat_taken = 1'b0;   // command beat accepted at the last rising edge
  logic    steady = 1'b0;       // no sender gaps while set
  int      mismatches = 0;
  int      cycle_count = 0;

  // Step past pos; past the last cell the screen scrolls up one row.
  function automatic logic roll_forward(input int pos);
    int nxt;
    nxt = pos + 1;
    if (nxt < CELLS) begin
      cursor = 11'(nxt);
      return 1'b0;
    end
    for (int i = 0; i < CELLS - COLS; i++) screen[i] = screen[i + COLS];
    for (int i = CELLS - COLS; i < CELLS; i++) screen[i] = '0;
    cursor = 11'(nxt - COLS);
    return 1'b1;
  endfunction

  // Newline writes nothing; it jumps to the last column so the step wraps.
  function automatic logic place_char(input int pos, input logic [7:0] ch,
                                      input logic [7:0] at);
    int         p;
    logic [7:0] a;
    p = (pos >= CELLS) ? 0 : pos;
    a = (at == 8'h00) ? blank_attr : at;
    if (ch == NEWLINE) p = (p / COLS) * COLS + COLS - 1;
    else screen[p] = {a, ch};
    return roll_forward(p);
  endfunction

  // Out-of-range column and row clamp to the last one.
  function automatic int cell_of(input logic [6:0] c, input logic [4:0] r);
    int cc;
    int rr;
    cc = (c >= COLS) ? COLS - 1 : int'(c);
    rr = (r >= ROWS) ? ROWS - 1 : int'(r);
    return rr * COLS + cc;
  endfunction

  function automatic result_t apply_command(input item_t it);
    result_t r;
    int      p;
    r = '0;
    case (it.cmd)
      CMD_PUT_CURSOR: r.scrolled = place_char(cursor, it.char_code, it.attr);
      CMD_PUT_POS:    r.scrolled = place_char(cell_of(it.col, it.row), it.char_code,
                                              it.attr);
      CMD_ERASE: begin
        // nothing to erase at the home cell
        if (cursor != 0) begin
          p = cursor - 1;
          screen[p] = {blank_attr, SPACE};
          cursor = 11'(p);
        end
      end
      CMD_CLEAR: begin
        // blank fill, then the final step scrolls once: bottom row ends zero
        for (int i = 0; i < CELLS; i++) screen[i] = {blank_attr, SPACE};
        r.scrolled = roll_forward(CELLS - 1);
        cursor = '0;
      end
      CMD_READ: begin
        p = cell_of(it.col, it.row);
        {r.read_attr, r.read_char} = screen[p];
      end
      default: ;
    endcase
    r.cursor_cell = cursor;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: register writes, accepted commands and result beats at the rising edge
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      for (int i = 0; i < CELLS; i++) screen[i] = '0;
      cursor = '0;
      blank_attr = ATTR_RESET;
      beat_taken <= 1'b0;
    end else begin
      if (cfg_we) blank_attr = cfg_data;
      beat_taken <= start && !busy;
      if (start && !busy) awaited.push_back(apply_command(cmd_beat));
      if (done) begin
        if (awaited.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("[%0t] result beat with none expected: cursor %0d char %h attr %h sc %b",
                     $time, res_beat.cursor_cell, res_beat.read_char, res_beat.read_attr,
                     res_beat.scrolled);
        end else begin
          want = awaited.pop_front();
          if (res_beat.cursor_cell !== want.cursor_cell ||
              res_beat.read_char !== want.read_char ||
              res_beat.read_attr !== want.read_attr ||
              res_beat.scrolled !== want.scrolled) begin
            mismatches++;
            if (mismatches <= 10)
              $display("[%0t] mismatch: want cursor %0d char %h attr %h sc %b, got %0d %h %h %b",
                       $time, want.cursor_cell, want.read_char, want.read_attr,
                       want.scrolled, res_beat.cursor_cell, res_beat.read_char,
                       res_beat.read_attr, res_beat.scrolled);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driver: one command beat at a time, changed at the falling edge. A beat is
  // held until taken; about one free slot in five is left idle unless steady.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!start || beat_taken) begin
      if (cmd_backlog.size() != 0 && (steady || $urandom_range(0, 99) >= 20)) begin
        cmd_beat <= cmd_backlog.pop_front();
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic queue_cmd(input logic [2:0] cmd, input logic [7:0] ch,
                           input logic [7:0] at, input logic [6:0] c, input logic [4:0] r);
    item_t it;
    it.cmd = cmd;
    it.char_code = ch;
    it.attr = at;
    it.col = c;
    it.row = r;
    cmd_backlog.push_back(it);
  endtask

  // Mostly text at the cursor with some newlines, positioned puts that drag the
  // cursor around (often onto the bottom row, so scrolls are common), reads,
  // erases, rare clears and a few unused codes. Ignored fields are random too.
  function automatic item_t draw_command();
    item_t it;
    int    pick;
    pick = $urandom_range(0, 999);
    if (pick < 520)      it.cmd = CMD_PUT_CURSOR;
    else if (pick < 680) it.cmd = CMD_PUT_POS;
    else if (pick < 760) it.cmd = CMD_ERASE;
    else if (pick < 940) it.cmd = CMD_READ;
    else if (pick < 948) it.cmd = CMD_CLEAR;
    else                 it.cmd = 3'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
    pick = $urandom_range(0, 99);
    if (pick < 8)       it.char_code = NEWLINE;
    else if (pick < 80) it.char_code = 8'($urandom_range(SPACE, PRINTABLE_LAST));
    else                it.char_code = 8'($urandom);
    it.attr = ($urandom_range(0, 99) < 30) ? 8'h00 : 8'($urandom);
    it.col = ($urandom_range(0, 99) < 80) ? 7'($urandom_range(0, COLS - 1)) : 7'($urandom);
    it.row = ($urandom_range(0, 99) < 75) ? 5'($urandom_range(0, ROWS - 1)) : 5'($urandom);
    return it;
  endfunction

  // Idle: every command handed over and every result beat back.
  task automatic wait_drained();
    while (cmd_backlog.size() != 0 || start || awaited.size() != 0) @(negedge clk);
  endtask

  initial begin
    logic [7:0] phase_attr [N_PHASES];
    phase_attr[0] = 8'h00;
    phase_attr[1] = 8'hFF;
    phase_attr[2] = 8'($urandom_range(1, 254));
    phase_attr[3] = 8'hAA;

    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // Directed pass at the reset attribute. The store is zero after reset.
    queue_cmd(CMD_READ,       8'h00,   8'h00, 7'd0,   5'd0);
    queue_cmd(CMD_PUT_CURSOR, 8'h41,   8'h00, 7'd0,   5'd0);   // default attribute
    queue_cmd(CMD_PUT_CURSOR, 8'hFF,   8'hFF, 7'd0,   5'd0);
    queue_cmd(CMD_PUT_CURSOR, 8'h00,   8'h01, 7'd0,   5'd0);
    queue_cmd(CMD_PUT_CURSOR, NEWLINE, 8'h00, 7'd0,   5'd0);   // to start of row 1
    queue_cmd(CMD_ERASE,      8'h00,   8'h00, 7'd0,   5'd0);   // blanks end of row 0
    queue_cmd(CMD_READ,       8'h00,   8'h00, 7'd79,  5'd0);
    queue_cmd(CMD_PUT_POS,    8'h5A,   8'h80, 7'd79,  5'd24);  // last cell: scroll
    queue_cmd(CMD_PUT_POS,    8'h71,   8'h00, 7'd127, 5'd31);  // clamped to last cell
    queue_cmd(CMD_PUT_POS,    NEWLINE, 8'h00, 7'd5,   5'd3);   // start of row 4
    queue_cmd(CMD_PUT_POS,    NEWLINE, 8'h00, 7'd0,   5'd24);  // newline off bottom row
    queue_cmd(CMD_READ,       8'h00,   8'h00, 7'd127, 5'd31);  // zeroed bottom row
    queue_cmd(CMD_READ,       8'h00,   8'h00, 7'd79,  5'd22);
    queue_cmd(CMD_READ,       8'h00,   8'h00, 7'd0,   5'd0);
    queue_cmd(CMD_PUT_CURSOR, 8'h78,   8'h7F, 7'd0,   5'd0);
    queue_cmd(CMD_CLEAR,      8'h00,   8'h00, 7'd0,   5'd0);
    queue_cmd(CMD_ERASE,      8'h00,   8'h00, 7'd0,   5'd0);   // at home: no change
    queue_cmd(CMD_READ,       8'h00,   8'h00, 7'd0,   5'd0);
    queue_cmd(CMD_READ,       8'h00,   8'h00, 7'd40,  5'd24);
    queue_cmd(CMD_UNUSED_LO,  8'h55,   8'hAA, 7'd42,  5'd9);
    queue_cmd(CMD_UNUSED_HI,  8'hFF,   8'hFF, 7'd127, 5'd31);
    queue_cmd(CMD_PUT_CURSOR, 8'hFF,   8'h00, 7'd127, 5'd31);  // col/row ignored here
    queue_cmd(CMD_READ,       8'h00,   8'h00, 7'd127, 5'd0);
    queue_cmd(CMD_READ,       8'h00,   8'h00, 7'd0,   5'd31);
    wait_drained();

    // Random phases, each under its own blank attribute; the second one runs
    // without sender gaps.
    for (int ph = 0; ph < N_PHASES; ph++) begin
      cfg_we <= 1'b1;
      cfg_data <= phase_attr[ph];
      @(negedge clk);
      cfg_we <= 1'b0;
      steady = (ph == 1);
      repeat (PHASE_ITEMS) cmd_backlog.push_back(draw_command());
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatches == 0 && awaited.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
